// ===== hw/rtl/did_pkg.sv =====
// Shared types and constants for the delta instruction decoder.
`timescale 1ns / 1ps

package did_pkg;

  // Default width of the size varints
  localparam int DID_SIZE_BITS = 32;

  // Field widths fixed by the delta format
  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int CLEN_W   = 24;
  localparam int COUNT_W  = 7;

  // Copy length that a zero size encoding stands for
  localparam logic [CLEN_W-1:0] ZERO_COPY_LEN = 24'h01_0000;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_BASE     = 3'd0,
    KIND_TARGET   = 3'd1,
    KIND_COPY     = 3'd2,
    KIND_LITERAL  = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } did_kind_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_BASE   = 3'd0,
    PH_TARGET = 3'd1,
    PH_CMD    = 3'd2,
    PH_COPY   = 3'd3,
    PH_INSERT = 3'd4,
    PH_DROP   = 3'd5
  } did_phase_t;

  // One result word
  typedef struct packed {
    did_kind_t         kind;
    logic [VALUE_W-1:0] value;
    logic [CLEN_W-1:0]  copy_length;
    logic [BYTE_W-1:0]  literal;
    logic              base_mismatch;
    logic              last;
  } did_result_t;

endpackage

// ===== hw/rtl/did_parse.sv =====
// Per-byte parser: stream state and the decode of one delta byte.
`timescale 1ns / 1ps

module did_parse import did_pkg::*; #(
  parameter int SIZE_BITS = DID_SIZE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [BYTE_W-1:0]  byte_i,
  input  logic               fin_i,
  input  logic [VALUE_W-1:0] base_length,
  output logic               emit,
  output did_result_t        res
);

  localparam int POS_W = $clog2(SIZE_BITS + 7);

  did_phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0]     cmd_r, cmd_nxt;
  logic [VALUE_W-1:0]     off_r, off_nxt;
  logic [SIZE_BITS-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  logic [COUNT_W-1:0]     payload;
  logic [SIZE_BITS+6:0]   vshift;
  logic                   pos_full;
  logic                   v_over;
  logic [COUNT_W-1:0]     pick;
  logic [COUNT_W-1:0]     cmd_left;
  logic [CLEN_W-1:0]      copy_sz;

  // Place the seven payload bits at the current varint position
  assign payload  = byte_i[COUNT_W-1:0];
  assign vshift   = {{SIZE_BITS{1'b0}}, payload} << pos_r;
  assign pos_full = (pos_r >= POS_W'(SIZE_BITS));
  assign v_over   = pos_full ? (payload != '0)
                             : (vshift[SIZE_BITS+6:SIZE_BITS] != '0);

  // Isolate the lowest pending operand bit of the copy command
  assign pick     = cmd_r & (~cmd_r + COUNT_W'(1));
  assign cmd_left = cmd_r & ~pick;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    off_nxt   = off_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    res       = '0;
    res.kind  = KIND_BASE;
    res.last  = fin_i;
    copy_sz   = '0;

    case (phase_r)
      PH_BASE, PH_TARGET: begin
        if (v_over) begin
          res.kind  = KIND_OVERFLOW;
          emit      = 1'b1;
          phase_nxt = PH_DROP;
        end else begin
          acc_nxt = acc_r | vshift[SIZE_BITS-1:0];
          // hold the position once it reaches the size width
          pos_nxt = pos_full ? pos_r : pos_r + POS_W'(7);
          if (byte_i[BYTE_W-1]) begin
            // more varint bytes follow
            if (fin_i) begin
              res.kind = KIND_TRUNC;
              emit     = 1'b1;
            end
          end else if (phase_r == PH_BASE) begin
            if (fin_i) begin
              res.kind = KIND_TRUNC;
            end else begin
              res.kind          = KIND_BASE;
              res.value         = acc_nxt[VALUE_W-1:0];
              res.base_mismatch = (acc_nxt != SIZE_BITS'(base_length));
            end
            emit      = 1'b1;
            phase_nxt = PH_TARGET;
            acc_nxt   = '0;
            pos_nxt   = '0;
          end else begin
            res.kind  = KIND_TARGET;
            res.value = acc_nxt[VALUE_W-1:0];
            emit      = 1'b1;
            phase_nxt = PH_CMD;
            acc_nxt   = '0;
            pos_nxt   = '0;
          end
        end
      end

      PH_CMD: begin
        if (byte_i[BYTE_W-1]) begin
          // copy command: latch operand mask
          cmd_nxt = payload;
          off_nxt = '0;
          acc_nxt = '0;
          if (payload == '0) begin
            res.kind        = KIND_COPY;
            res.copy_length = ZERO_COPY_LEN;
            emit            = 1'b1;
          end else begin
            phase_nxt = PH_COPY;
            if (fin_i) begin
              res.kind = KIND_TRUNC;
              emit     = 1'b1;
            end
          end
        end else if (payload != '0) begin
          // insert command: count literal bytes
          rem_nxt   = payload;
          phase_nxt = PH_INSERT;
          if (fin_i) begin
            res.kind = KIND_TRUNC;
            emit     = 1'b1;
          end
        end
      end

      PH_COPY: begin
        // merge this operand byte into offset or size
        for (int k = 0; k < 4; k++) begin
          off_nxt[8*k +: 8] = off_r[8*k +: 8] | (pick[k] ? byte_i : 8'h00);
        end
        for (int k = 0; k < 3; k++) begin
          acc_nxt[8*k +: 8] = acc_r[8*k +: 8] | (pick[4+k] ? byte_i : 8'h00);
        end
        cmd_nxt = cmd_left;
        copy_sz = acc_nxt[CLEN_W-1:0];
        if (cmd_left == '0) begin
          res.kind        = KIND_COPY;
          res.value       = off_nxt;
          res.copy_length = (copy_sz == '0) ? ZERO_COPY_LEN : copy_sz;
          emit            = 1'b1;
          phase_nxt       = PH_CMD;
        end else if (fin_i) begin
          res.kind = KIND_TRUNC;
          emit     = 1'b1;
        end
      end

      PH_INSERT: begin
        emit = 1'b1;
        if (rem_r != '0) begin
          rem_nxt = rem_r - COUNT_W'(1);
        end
        if (rem_nxt == '0) begin
          res.kind    = KIND_LITERAL;
          res.literal = byte_i;
          phase_nxt   = PH_CMD;
        end else if (fin_i) begin
          res.kind = KIND_TRUNC;
        end else begin
          res.kind    = KIND_LITERAL;
          res.literal = byte_i;
        end
      end

      default: begin
        // drop the rest of a stream after an overflow
      end
    endcase

    // Return to the start of a stream after its final byte
    if (fin_i) begin
      phase_nxt = PH_BASE;
      cmd_nxt   = '0;
      off_nxt   = '0;
      acc_nxt   = '0;
      rem_nxt   = '0;
      pos_nxt   = '0;
    end
  end

  // Advance stream state once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BASE;
      cmd_r   <= '0;
      off_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      off_r   <= off_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== hw/rtl/delta_instruction_decoder.sv =====
// Top level of the delta instruction decoder: input register, parser, result register.
// Decodes a pack delta stream one byte per cycle. Each accepted byte is held in an
// input register, decoded in a single pass by the parser and the result, if any, is
// placed in a result register, so a byte's result passes the input register and then
// the result register, and a new byte is taken in every cycle while results keep
// draining. This rate is set by the loop through the parser's phase and accumulator
// registers, which each byte updates once. Bytes that cause no result (continuation
// bytes, command zero, copy operands before the last) still pass through the parser.
// base_length must be written through cfg_we and cfg_wdata only while the block is
// idle; the block itself does not enforce this. There is no clearing pass after reset.
`timescale 1ns / 1ps

module delta_instruction_decoder import did_pkg::*; #(
  parameter int SIZE_BITS = DID_SIZE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_delta_byte,
  input  logic               in_end_of_delta,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [VALUE_W-1:0] out_value,
  output logic [CLEN_W-1:0]  out_copy_length,
  output logic [BYTE_W-1:0]  out_literal,
  output logic               out_base_mismatch,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata
);

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_fin_r;
  logic               out_valid_r;
  did_result_t        out_res_r;
  logic [VALUE_W-1:0] base_length_r;

  logic               advance;
  logic               emit;
  did_result_t        res;

  // Process the held word when the result register can take its outcome
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Hold the configured base length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= '0;
    end else if (cfg_we) begin
      base_length_r <= cfg_wdata;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_delta_byte;
      in_fin_r  <= in_end_of_delta;
    end
  end

  did_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .byte_i      (in_byte_r),
    .fin_i       (in_fin_r),
    .base_length (base_length_r),
    .emit        (emit),
    .res         (res)
  );

  // Load a new result or drop the one just taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_value         = out_res_r.value;
  assign out_copy_length   = out_res_r.copy_length;
  assign out_literal       = out_res_r.literal;
  assign out_base_mismatch = out_res_r.base_mismatch;
  assign out_last          = out_res_r.last;

endmodule

// ===== hw/rtl/did_checker.sv =====
// Port-level checks for the delta instruction decoder, bound to the top level.
`timescale 1ns / 1ps

module did_checker import did_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [BYTE_W-1:0]  in_delta_byte,
  input logic               in_end_of_delta,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_kind,
  input logic [VALUE_W-1:0] out_value,
  input logic [CLEN_W-1:0]  out_copy_length,
  input logic [BYTE_W-1:0]  out_literal,
  input logic               out_base_mismatch,
  input logic               out_last
);

  // A waiting input word keeps its contents
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_delta_byte)
      && $stable(in_end_of_delta))
    else $error("input word changed while waiting");

  // A stalled result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_copy_length) && $stable(out_literal)
      && $stable(out_base_mismatch) && $stable(out_last))
    else $error("result word changed while stalled");

  // Mismatch flag belongs to the base size word only
  a_mismatch_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_base_mismatch |-> out_kind == KIND_BASE)
    else $error("base mismatch flagged on a non-base word");

  // A copy never reports zero length
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_COPY |-> out_copy_length != '0)
    else $error("copy with zero length");

  // Truncation is only reported on the final byte
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TRUNC |-> out_last)
    else $error("truncation without end of stream");

endmodule

bind delta_instruction_decoder did_checker u_did_checker (.*);

// ===== tb/delta_instruction_decoder_checker.sv =====
// Checker for the delta instruction decoder: predicts every result word and compares it.
`timescale 1ns / 1ps

module delta_instruction_decoder_checker import did_pkg::*; #(
  parameter int SIZE_BITS = DID_SIZE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [BYTE_W-1:0]  in_delta_byte,
  input  logic               in_end_of_delta,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_kind,
  input  logic [VALUE_W-1:0] out_value,
  input  logic [CLEN_W-1:0]  out_copy_length,
  input  logic [BYTE_W-1:0]  out_literal,
  input  logic               out_base_mismatch,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 outstanding,
  output int                 words_checked
);

  // Shadow parser state
  did_phase_t   parse_phase;
  logic [6:0]   ops_left;
  logic [31:0]  offset_acc;
  logic [63:0]  size_acc;
  logic [6:0]   literals_left;
  int unsigned  bit_pos;
  logic [31:0]  base_len;

  // Result words still owed by the block, oldest first
  did_result_t  decoded_words[$];
  int           fails;
  int           checked;

  task automatic restart_stream();
    parse_phase   = PH_BASE;
    ops_left      = '0;
    offset_acc    = '0;
    size_acc      = '0;
    literals_left = '0;
    bit_pos       = 0;
  endtask

  // Advance the shadow parser by one stream byte; flag a result word if one is due
  task automatic decode_byte(input logic [7:0] b, input logic fin,
                             output bit hit, output did_result_t r);
    logic [63:0] payload;
    bit          ovf;
    int unsigned room;
    int          sel;
    hit             = 1'b0;
    r.kind          = KIND_BASE;
    r.value         = '0;
    r.copy_length   = '0;
    r.literal       = '0;
    r.base_mismatch = 1'b0;
    r.last          = fin;
    case (parse_phase)
      PH_BASE, PH_TARGET: begin
        payload = {57'd0, b[6:0]};
        ovf = 1'b0;
        // Payload bits at or above the size width overflow; zero padding is fine
        if (bit_pos >= SIZE_BITS) begin
          ovf = (payload != 0);
        end else begin
          room = SIZE_BITS - bit_pos;
          if (room < 7 && (payload >> room) != 0) begin
            ovf = 1'b1;
          end else begin
            size_acc = size_acc | (payload << bit_pos);
            if (bit_pos < 120) bit_pos = bit_pos + 7;
          end
        end
        if (ovf) begin
          hit = 1'b1;
          r.kind = KIND_OVERFLOW;
          parse_phase = PH_DROP;
        end else if (b[7]) begin
          if (fin) begin
            hit = 1'b1;
            r.kind = KIND_TRUNC;
          end
        end else begin
          hit = 1'b1;
          if (parse_phase == PH_BASE) begin
            // Ending on the base size still leaves the target size missing
            if (fin) begin
              r.kind = KIND_TRUNC;
            end else begin
              r.kind = KIND_BASE;
              r.value = size_acc[31:0];
              r.base_mismatch = (size_acc != {32'd0, base_len});
            end
            parse_phase = PH_TARGET;
          end else begin
            r.kind = KIND_TARGET;
            r.value = size_acc[31:0];
            parse_phase = PH_CMD;
          end
          size_acc = '0;
          bit_pos = 0;
        end
      end
      PH_CMD: begin
        if (b[7]) begin
          ops_left = b[6:0];
          offset_acc = '0;
          size_acc = '0;
          // A bare copy command means offset zero, full 64 KiB length
          if (ops_left == 0) begin
            hit = 1'b1;
            r.kind = KIND_COPY;
            r.copy_length = ZERO_COPY_LEN;
          end else begin
            parse_phase = PH_COPY;
            if (fin) begin
              hit = 1'b1;
              r.kind = KIND_TRUNC;
            end
          end
        end else if (b[6:0] != 0) begin
          literals_left = b[6:0];
          parse_phase = PH_INSERT;
          if (fin) begin
            hit = 1'b1;
            r.kind = KIND_TRUNC;
          end
        end
      end
      PH_COPY: begin
        // Operand bytes follow the mask bits, lowest first
        sel = 7;
        for (int i = 6; i >= 0; i--) if (ops_left[i]) sel = i;
        if (sel < 4) offset_acc = offset_acc | ({24'd0, b} << (8 * sel));
        else if (sel < 7) size_acc = size_acc | ({56'd0, b} << (8 * (sel - 4)));
        if (sel < 7) ops_left[sel] = 1'b0;
        if (ops_left == 0) begin
          hit = 1'b1;
          r.kind = KIND_COPY;
          r.value = offset_acc;
          r.copy_length = (size_acc == 0) ? ZERO_COPY_LEN : size_acc[23:0];
          parse_phase = PH_CMD;
        end else if (fin) begin
          hit = 1'b1;
          r.kind = KIND_TRUNC;
        end
      end
      PH_INSERT: begin
        hit = 1'b1;
        if (literals_left > 0) literals_left = literals_left - 7'd1;
        if (literals_left == 0) begin
          r.kind = KIND_LITERAL;
          r.literal = b;
          parse_phase = PH_CMD;
        end else if (fin) begin
          r.kind = KIND_TRUNC;
        end else begin
          r.kind = KIND_LITERAL;
          r.literal = b;
        end
      end
      default: begin
        // Drop everything after an overflow until the stream ends
      end
    endcase
    if (fin) restart_stream();
  endtask

  // Watch both channels and the register port on every edge
  always @(posedge clk) begin : watch
    bit          hit;
    did_result_t r;
    did_result_t e;
    if (!rst_n) begin
      restart_stream();
      base_len = '0;
      decoded_words.delete();
    end else begin
      if (cfg_we === 1'b1) base_len = cfg_wdata;
      // Compare an accepted result word with the oldest prediction
      if (out_valid === 1'b1 && out_ready) begin
        checked++;
        if (decoded_words.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result word kind %0d value %h last %b",
                     $time, out_kind, out_value, out_last);
        end else begin
          e = decoded_words.pop_front();
          if (out_kind !== e.kind || out_value !== e.value ||
              out_copy_length !== e.copy_length || out_literal !== e.literal ||
              out_base_mismatch !== e.base_mismatch || out_last !== e.last) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: result word differs (expected/actual): kind %0d/%0d ",
                        "value %h/%h len %h/%h lit %h/%h mm %b/%b last %b/%b"},
                       $time, e.kind, out_kind, e.value, out_value,
                       e.copy_length, out_copy_length, e.literal, out_literal,
                       e.base_mismatch, out_base_mismatch, e.last, out_last);
          end
        end
      end
      // Predict from an accepted stream byte
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        decode_byte(in_delta_byte, in_end_of_delta, hit, r);
        if (hit) decoded_words.insert(decoded_words.size(), r);
      end
    end
    outstanding   <= decoded_words.size();
    fail_count    <= fails;
    words_checked <= checked;
  end

endmodule

// ===== tb/delta_instruction_decoder_tb.sv =====
// Top of the delta instruction decoder testbench: clock, reset, stream stimulus and verdict.
`timescale 1ns / 1ps

module delta_instruction_decoder_tb;
  import did_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_delta_byte = '0;
  logic               in_end_of_delta = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_kind;
  logic [VALUE_W-1:0] out_value;
  logic [CLEN_W-1:0]  out_copy_length;
  logic [BYTE_W-1:0]  out_literal;
  logic               out_base_mismatch;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [VALUE_W-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int words_checked;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          words_sent = 0;
  int          streams_sent = 0;
  logic [31:0] cur_base = '0;
  logic [7:0]  stream_bytes[$];

  always #2 clk = ~clk;

  delta_instruction_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_delta_byte     (in_delta_byte),
    .in_end_of_delta   (in_end_of_delta),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_copy_length   (out_copy_length),
    .out_literal       (out_literal),
    .out_base_mismatch (out_base_mismatch),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  delta_instruction_decoder_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_delta_byte     (in_delta_byte),
    .in_end_of_delta   (in_end_of_delta),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_copy_length   (out_copy_length),
    .out_literal       (out_literal),
    .out_base_mismatch (out_base_mismatch),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .words_checked     (words_checked)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hold one byte on the input channel until it is taken
  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_delta_byte   <= b;
    in_end_of_delta <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_stream();
    for (int k = 0; k < stream_bytes.size(); k++)
      send_word(stream_bytes[k], k == stream_bytes.size() - 1);
    streams_sent++;
  endtask

  // Drain the block, then write base_length while it is idle
  task automatic write_base_length(input logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_base = v;
  endtask

  // Add one byte to the end of the stream being built
  task automatic append_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endtask

  // Little-endian base-128 encoding, optionally padded with zero-payload bytes
  task automatic add_varint(input logic [63:0] v, input int pad);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0 || pad > 0) b[7] = 1'b1;
      append_byte(b);
    end while (v != 0);
    for (int k = 0; k < pad; k++) append_byte((k == pad - 1) ? 8'h00 : 8'h80);
  endtask

  function automatic int pick_pad();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(1, 4);
    if (roll < 13) return $urandom_range(10, 20);
    return 0;
  endfunction

  function automatic logic [63:0] pick_size();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return 64'($urandom_range(1, 127));
      2:       return 64'($urandom_range(128, 65535));
      3:       return {32'd0, $urandom};
      4:       return 64'h0000_0000_FFFF_FFFF;
      default: return 64'($urandom_range(1, 1 << 21));
    endcase
  endfunction

  // Mostly well-formed streams, some cut short, some overflowing, a few pure noise
  task automatic build_random_stream();
    int          shape;
    int          cut;
    int          n_ops;
    int          op;
    int          count;
    int          roll;
    logic [6:0]  mask;
    logic [63:0] base_sz;
    logic [63:0] huge;
    shape = $urandom_range(99);
    stream_bytes.delete();
    base_sz = ($urandom_range(1) == 1) ? {32'd0, cur_base} : pick_size();
    huge = (64'($urandom_range(1, 255)) << 32) | {32'd0, $urandom};
    if (shape >= 93) begin
      repeat ($urandom_range(1, 20)) append_byte(8'($urandom));
      return;
    end
    if (shape >= 87) begin
      if ($urandom_range(1) == 1) begin
        add_varint(huge, 0);
      end else begin
        add_varint(base_sz, pick_pad());
        add_varint(huge, 0);
      end
      repeat ($urandom_range(5)) append_byte(8'($urandom));
      return;
    end
    add_varint(base_sz, pick_pad());
    add_varint(pick_size(), pick_pad());
    n_ops = $urandom_range(1, 6);
    repeat (n_ops) begin
      op = $urandom_range(99);
      if (op < 45) begin
        mask = 7'($urandom);
        append_byte({1'b1, mask});
        for (int k = 0; k < 7; k++) begin
          if (mask[k]) begin
            roll = $urandom_range(99);
            append_byte(roll < 15 ? 8'h00 : roll < 25 ? 8'hFF : 8'($urandom));
          end
        end
      end else if (op < 90) begin
        count = ($urandom_range(9) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 127);
        append_byte(8'(count));
        repeat (count) append_byte(8'($urandom));
      end else begin
        append_byte(8'h00);
      end
    end
    // Cut a share of them short at any byte
    if (shape >= 75 && stream_bytes.size() > 1) begin
      cut = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
  endtask

  initial begin : stimulus
    logic [31:0] base_settings[6];
    int          idle_settings[6];
    int          stall_settings[6];
    int          waited;
    int          leftover;
    base_settings  = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0000_4000, 32'hFFFF_FFFF};
    base_settings[2] = $urandom_range(1, 127);
    base_settings[3] = $urandom;
    idle_settings  = '{0, 70, 0, 15, 0, 15};
    stall_settings = '{0, 0, 70, 15, 0, 15};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero sizes, the target one padded, bare copy, one literal, command zero as the final byte
    stream_bytes = '{8'h00, 8'h80, 8'h00, 8'h80, 8'h01, 8'hAB, 8'h00};
    send_stream();
    // Widest base size, full copy with all operand bytes ending the stream
    stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'hFF,
                     8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
    send_stream();
    // Stream that ends on its base size
    stream_bytes = '{8'h05};
    send_stream();
    // Varint reaching bit 32, then a dropped final byte
    stream_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h33};
    send_stream();

    // Random phases, each setting a register value and an idle and stall mix
    for (int p = 0; p < 6; p++) begin
      write_base_length(base_settings[p]);
      idle_pct  = idle_settings[p];
      stall_pct = stall_settings[p];
      while (words_sent < 30 + (p + 1) * 300) begin
        build_random_stream();
        send_stream();
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    leftover = outstanding;

    $display("summary: %0d stream bytes in %0d streams, %0d result words checked",
             words_sent, streams_sent, words_checked);
    $display("summary: six base_length values incl. zero and all ones, idle/stall 0-70%%");
    if (fail_count + leftover == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== delta_instruction_decoder.f =====
hw/rtl/did_pkg.sv
hw/rtl/did_parse.sv
hw/rtl/delta_instruction_decoder.sv
hw/rtl/did_checker.sv
tb/delta_instruction_decoder_checker.sv
tb/delta_instruction_decoder_tb.sv
